@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the scheduler core.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a consequence in the same cycle as its trigger
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its trigger
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/pps_pkg.sv @@
// Shared types and constants for the preemptive priority scheduler core.
// No dependencies; imported by every module of the core.
package pps_pkg;

  localparam int MAX_TASKS = 16;
  localparam int SLOT_W    = $clog2(MAX_TASKS);
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);
  localparam int TIME_W    = 24;
  localparam int VAL_W     = 16;
  localparam int PRI_W     = 8;
  localparam int CFG_W     = 5;
  localparam int IN_DATA_W = 48;
  localparam int OUT_DATA_W = 104;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // Request kinds carried on in_tuser
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // One table entry as loaded
  typedef struct packed {
    logic [VAL_W-1:0] arrival;
    logic [VAL_W-1:0] burst;
    logic [PRI_W-1:0] priority_level;
  } pps_entry_t;

  // Read view of one table slot
  typedef struct packed {
    pps_entry_t       entry;
    logic [VAL_W-1:0] remaining;
    logic             started;
  } pps_rd_t;

  // Remaining-work update of one slot after it runs
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    logic [VAL_W-1:0]  remaining;
  } pps_upd_t;

  // Result word, most significant field first, matches out_tdata
  typedef struct packed {
    logic [TIME_W-1:0] time_now;
    logic              all_done;
    logic [TIME_W-1:0] waiting_time;
    logic [TIME_W-1:0] turnaround_time;
    logic [TIME_W-1:0] completion_time;
    logic              finished;
    logic              first_start;
    logic              switched;
    logic [SLOT_W-1:0] chosen_slot;
  } pps_res_t;

endpackage

@@ rtl/core/pps_alu.sv @@
// Shared subtract/compare unit of the scheduler core.
// Depends on pps_pkg for the time width.
module pps_alu import pps_pkg::*; (
  input  logic [TIME_W-1:0] a,
  input  logic [TIME_W-1:0] b,
  output logic [TIME_W-1:0] diff,
  output logic              borrow
);

  logic [TIME_W:0] wide;

  // Subtract with borrow out: borrow means a < b
  assign wide   = {1'b0, a} - {1'b0, b};
  assign diff   = wide[TIME_W-1:0];
  assign borrow = wide[TIME_W];

endmodule

@@ rtl/core/pps_table.sv @@
// Task table of the scheduler core: entries, remaining work, started flags.
// Depends on pps_pkg for entry and update types.
module pps_table import pps_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [SLOT_W-1:0] wr_slot,
  input  pps_entry_t        wr_entry,
  input  pps_upd_t          upd,
  input  logic [SLOT_W-1:0] rd_slot,
  output pps_rd_t           rd
);

  pps_entry_t       entry_r     [MAX_TASKS];
  logic [VAL_W-1:0] remaining_r [MAX_TASKS];
  logic             started_r   [MAX_TASKS];

  // Hold loaded entries, no reset needed
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_r[wr_slot] <= wr_entry;
    end
  end

  // Track remaining work and first-run flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_TASKS; i++) begin
        remaining_r[i] <= '0;
        started_r[i]   <= 1'b0;
      end
    end else if (wr_en) begin
      remaining_r[wr_slot] <= wr_entry.burst;
      started_r[wr_slot]   <= 1'b0;
    end else if (upd.en) begin
      remaining_r[upd.slot] <= upd.remaining;
      started_r[upd.slot]   <= 1'b1;
    end
  end

  // Read the selected slot
  always_comb begin
    rd.entry     = entry_r[rd_slot];
    rd.remaining = remaining_r[rd_slot];
    rd.started   = started_r[rd_slot];
  end

endmodule

@@ rtl/core/preemptive_priority_scheduler_core.sv @@
// Top level of the preemptive priority scheduler core: sequencer, result register.
// Depends on pps_pkg, pps_table, pps_alu and assert_macros.svh.
//
//   channel  direction  handshake                  payload
//   in_      slave      in_tvalid / in_tready       in_tdata, in_tuser (kind)
//   out_     master     out_tvalid / out_tready     out_tdata, out_tuser (ran)
//   cfg_     slave      cfg_valid / cfg_ready       cfg_data (process_count)
//
// A load request passes through acceptance and the handoff to the result register.
// A tick request passes through acceptance, a scan of each table slot (16) through the
// shared compare unit, the update states ST_UPD and ST_FIN that reuse that unit, and
// the handoff; a tick with no ready task skips the update states.
// The input is not ready until the result is in the output register; that
// register then holds it while out_tready is low, beside the next request.
// Reset (rst_n, synchronous) clears time, remaining work and started flags.
`include "assert_macros.svh"

module preemptive_priority_scheduler_core import pps_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [3:0] slot, [19:4] arrival_time, [35:20] burst_length,
  // [43:36] priority_level, [47:44] zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [0] kind
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [3:0] chosen_slot, [4] switched, [5] first_start, [6] finished,
  // [30:7] completion_time, [54:31] turnaround_time, [78:55] waiting_time,
  // [79] all_done, [103:80] time_now
  output logic [OUT_DATA_W-1:0] out_tdata,
  // [0] ran
  output logic                  out_tuser,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_W-1:0]      cfg_data
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_UPD  = 3'd2;
  localparam logic [2:0] ST_FIN  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_TASKS - 1);
  localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_TASKS);
  localparam logic [PRI_W:0]    PRI_NONE  = {1'b1, {PRI_W{1'b0}}};

  logic [2:0]        state_r, state_nxt;
  logic [CFG_W-1:0]  pcount_r;
  logic [TIME_W-1:0] time_r, time_nxt;
  logic [TIME_W-1:0] t0_r, t0_nxt;
  logic [SLOT_W:0]   prev_r, prev_nxt;
  logic [SLOT_W-1:0] idx_r, idx_nxt;
  logic [SLOT_W-1:0] best_r, best_nxt;
  logic              found_r, found_nxt;
  logic [PRI_W:0]    bestpri_r, bestpri_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [TIME_W-1:0] tat_r, tat_nxt;
  logic [VAL_W-1:0]  burst_r, burst_nxt;
  logic              fin_r, fin_nxt;
  logic              first_r, first_nxt;
  logic              sw_r, sw_nxt;
  pps_res_t          res_r, res_nxt;
  logic              ran_r, ran_nxt;
  pps_res_t          out_r;
  logic              out_ran_r;
  logic              out_valid_r;

  logic              in_accept;
  logic              load_en;
  pps_entry_t        load_entry;
  pps_upd_t          upd;
  logic [SLOT_W-1:0] rd_slot;
  pps_rd_t           rd;
  logic [TIME_W-1:0] alu_a, alu_b, alu_diff;
  logic              alu_borrow;
  logic [CNT_W-1:0]  n_counted;
  logic              in_count;
  logic              is_ready;
  logic [TIME_W-1:0] comp_time;
  logic [VAL_W-1:0]  rem_dec;
  logic [CNT_W-1:0]  cnt_left;

  pps_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (load_en),
    .wr_slot  (in_tdata[SLOT_W-1:0]),
    .wr_entry (load_entry),
    .upd      (upd),
    .rd_slot  (rd_slot),
    .rd       (rd)
  );

  pps_alu u_alu (
    .a      (alu_a),
    .b      (alu_b),
    .diff   (alu_diff),
    .borrow (alu_borrow)
  );

  assign in_tready = (state_r == ST_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign load_en = in_accept && (in_tuser == KIND_LOAD);
  assign load_entry.arrival        = in_tdata[SLOT_W +: VAL_W];
  assign load_entry.burst          = in_tdata[SLOT_W + VAL_W +: VAL_W];
  assign load_entry.priority_level = in_tdata[SLOT_W + 2*VAL_W +: PRI_W];

  // Clamp the slot count to the table depth
  assign n_counted = ({1'b0, pcount_r} > {1'b0, CNT_MAX}) ? CNT_MAX : CNT_W'(pcount_r);
  assign in_count  = ({1'b0, idx_r} < n_counted);
  assign is_ready  = in_count && ({{(TIME_W-VAL_W){1'b0}}, rd.entry.arrival} <= t0_r)
                     && (rd.remaining != '0);
  assign comp_time = (t0_r == TIME_MAX) ? TIME_MAX : t0_r + 1'b1;
  assign rem_dec   = rd.remaining - 1'b1;
  assign cnt_left  = cnt_r - CNT_W'(fin_r);

  // Steer the table read port and the shared unit by state
  always_comb begin
    rd_slot = idx_r;
    alu_a   = '0;
    alu_b   = '0;
    case (state_r)
      ST_SCAN: begin
        alu_a = {{(TIME_W-PRI_W){1'b0}}, rd.entry.priority_level};
        alu_b = {{(TIME_W-PRI_W-1){1'b0}}, bestpri_r};
      end
      ST_UPD: begin
        rd_slot = best_r;
        alu_a   = comp_time;
        alu_b   = {{(TIME_W-VAL_W){1'b0}}, rd.entry.arrival};
      end
      ST_FIN: begin
        alu_a = tat_r;
        alu_b = {{(TIME_W-VAL_W){1'b0}}, burst_r};
      end
      default: begin
        rd_slot = idx_r;
      end
    endcase
  end

  assign upd.en        = (state_r == ST_UPD);
  assign upd.slot      = best_r;
  assign upd.remaining = rem_dec;

  // Sequence a load to its result, or a tick through scan, any update and result
  always_comb begin
    state_nxt   = state_r;
    time_nxt    = time_r;
    t0_nxt      = t0_r;
    prev_nxt    = prev_r;
    idx_nxt     = idx_r;
    best_nxt    = best_r;
    found_nxt   = found_r;
    bestpri_nxt = bestpri_r;
    cnt_nxt     = cnt_r;
    tat_nxt     = tat_r;
    burst_nxt   = burst_r;
    fin_nxt     = fin_r;
    first_nxt   = first_r;
    sw_nxt      = sw_r;
    res_nxt     = res_r;
    ran_nxt     = ran_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          if (in_tuser == KIND_LOAD) begin
            res_nxt          = '0;
            res_nxt.time_now = time_r;
            ran_nxt          = 1'b0;
            time_nxt         = '0;
            state_nxt        = ST_OUT;
          end else begin
            t0_nxt      = time_r;
            idx_nxt     = '0;
            found_nxt   = 1'b0;
            best_nxt    = '0;
            bestpri_nxt = PRI_NONE;
            cnt_nxt     = '0;
            state_nxt   = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // Keep the first strictly better ready slot
        if (is_ready && alu_borrow) begin
          found_nxt   = 1'b1;
          best_nxt    = idx_r;
          bestpri_nxt = {1'b0, rd.entry.priority_level};
        end
        cnt_nxt = cnt_r + CNT_W'(in_count && (rd.remaining != '0));
        idx_nxt = idx_r + 1'b1;
        if (idx_r == LAST_SLOT) begin
          if (found_nxt) begin
            state_nxt = ST_UPD;
          end else begin
            res_nxt          = '0;
            res_nxt.time_now = t0_r;
            res_nxt.all_done = (cnt_nxt == '0);
            ran_nxt          = 1'b0;
            time_nxt         = comp_time;
            state_nxt        = ST_OUT;
          end
        end
      end
      ST_UPD: begin
        tat_nxt   = alu_borrow ? '0 : alu_diff;
        burst_nxt = rd.entry.burst;
        fin_nxt   = (rem_dec == '0);
        first_nxt = !rd.started;
        sw_nxt    = ({1'b0, best_r} != prev_r);
        prev_nxt  = {1'b0, best_r};
        time_nxt  = comp_time;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        res_nxt                 = '0;
        res_nxt.chosen_slot     = best_r;
        res_nxt.switched        = sw_r;
        res_nxt.first_start     = first_r;
        res_nxt.finished        = fin_r;
        res_nxt.completion_time = fin_r ? time_r : '0;
        res_nxt.turnaround_time = fin_r ? tat_r : '0;
        res_nxt.waiting_time    = (fin_r && !alu_borrow) ? alu_diff : '0;
        res_nxt.all_done        = (cnt_left == '0);
        res_nxt.time_now        = t0_r;
        ran_nxt                 = 1'b1;
        state_nxt               = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Advance control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      time_r   <= '0;
      prev_r   <= (SLOT_W+1)'(MAX_TASKS);
      pcount_r <= '0;
    end else begin
      state_r <= state_nxt;
      time_r  <= time_nxt;
      prev_r  <= prev_nxt;
      if (cfg_valid && cfg_ready) begin
        pcount_r <= cfg_data;
      end
    end
  end

  // Hold working values of the request in flight
  always_ff @(posedge clk) begin
    t0_r      <= t0_nxt;
    idx_r     <= idx_nxt;
    best_r    <= best_nxt;
    found_r   <= found_nxt;
    bestpri_r <= bestpri_nxt;
    cnt_r     <= cnt_nxt;
    tat_r     <= tat_nxt;
    burst_r   <= burst_nxt;
    fin_r     <= fin_nxt;
    first_r   <= first_nxt;
    sw_r      <= sw_nxt;
    res_r     <= res_nxt;
    ran_r     <= ran_nxt;
  end

  // Move the finished result into the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_OUT && (!out_valid_r || out_tready)) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_OUT && (!out_valid_r || out_tready)) begin
      out_r     <= res_r;
      out_ran_r <= ran_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r;
  assign out_tuser  = out_ran_r;

  // A tick request leaves the scan once the last table slot is checked
  `ASSERT_NEXT(a_scan_ends, (state_r == ST_SCAN) && (idx_r == LAST_SLOT), state_r != ST_SCAN, "scan overran the table")
  // Time only moves backward on a load request
  `ASSERT_NEXT(a_time_mono, !(in_accept && (in_tuser == KIND_LOAD)), time_r >= $past(time_r), "time went backward without a load")
  // A result with no task run carries no per-task flags
  `ASSERT_SAME(a_idle_flags, out_valid_r && !out_ran_r, !out_r.finished && !out_r.first_start && !out_r.switched, "idle result carries task flags")

endmodule
